### design/bbf_pkg.sv
// Package for the band filter: widths, types and shared constants.
// No dependencies.
package bbf_pkg;

    localparam int WinMax    = 64;
    localparam int PosW      = 6;
    localparam int CntW      = 7;
    localparam int PriceW    = 24;
    localparam int SumW      = 30;
    localparam int SqW       = 54;
    localparam int BandW     = 26;
    localparam int QDepth    = 2;

    localparam logic [CntW-1:0] LenReset = 7'd20;

    // front-to-back request: the sums after one sample is taken in
    typedef struct packed {
        logic            full;
        logic [CntW-1:0] len;
        logic [SumW-1:0] sum;
        logic [SqW-1:0]  sq;
    } bbf_req_t;

    typedef struct packed {
        logic                    valid_res;
        logic [PriceW-1:0]       mean;
        logic [PriceW-1:0]       deviation;
        logic [BandW-1:0]        band_hi;
        logic signed [BandW-1:0] band_lo;
    } bbf_res_t;

endpackage

### design/bbf_front.sv
// Front end: delay line, running sum and sum of squares.
// Depends on bbf_pkg.
module bbf_front import bbf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr,
    input  logic [CntW-1:0]   cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PriceW-1:0] in_price,
    output logic              req_valid,
    input  logic              req_ready,
    output bbf_req_t          req
);

    typedef enum logic [1:0] {F_IDLE, F_READ, F_SQ, F_SEND} fstate_t;

    logic [PriceW-1:0] hist_mem [WinMax];
    logic [PriceW-1:0] old_reg, price_reg;
    logic [CntW-1:0]   len_cfg_reg, seen_reg;
    logic [PosW-1:0]   pos_reg;
    logic [SumW-1:0]   sum_reg;
    logic [SqW-1:0]    sq_reg;
    logic [2*PriceW-1:0] psq_reg, osq_reg;
    fstate_t           state_reg;
    logic [CntW-1:0]   len_eff;
    logic              was_full;

    always_comb begin
        if (len_cfg_reg == '0) len_eff = CntW'(1);
        else if (len_cfg_reg > CntW'(WinMax)) len_eff = CntW'(WinMax);
        else len_eff = len_cfg_reg;
    end

    assign was_full  = seen_reg >= len_eff;
    assign in_ready  = (state_reg == F_IDLE) && !cfg_wr;
    assign req_valid = (state_reg == F_SEND);
    assign req.full  = (seen_reg >= len_eff);
    assign req.len   = len_eff;
    assign req.sum   = sum_reg;
    assign req.sq    = sq_reg;

    // entries past seen_reg are never read, so no clearing needed
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && in_valid && !cfg_wr) begin
            old_reg <= hist_mem[pos_reg];
            price_reg <= in_price;
        end
        if (state_reg == F_READ) hist_mem[pos_reg] <= price_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            len_cfg_reg <= LenReset;
            seen_reg    <= '0;
            pos_reg     <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
        end else if (cfg_wr) begin
            state_reg   <= F_IDLE;
            len_cfg_reg <= cfg_data;
            seen_reg    <= '0;
            pos_reg     <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
        end else begin
            case (state_reg)
                F_IDLE: if (in_valid) state_reg <= F_READ;
                F_READ: begin
                    psq_reg <= price_reg * price_reg;
                    osq_reg <= was_full ? old_reg * old_reg : '0;
                    sum_reg <= sum_reg + SumW'(price_reg)
                               - (was_full ? SumW'(old_reg) : '0);
                    state_reg <= F_SQ;
                end
                F_SQ: begin
                    sq_reg <= sq_reg + SqW'(psq_reg) - SqW'(osq_reg);
                    if (CntW'(pos_reg) + 1'b1 >= len_eff) pos_reg <= '0;
                    else pos_reg <= pos_reg + 1'b1;
                    if (!was_full) seen_reg <= seen_reg + 1'b1;
                    state_reg <= F_SEND;
                end
                F_SEND: if (req_ready) state_reg <= F_IDLE;
                default: state_reg <= F_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= len_eff) else $error("sample count past window");
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CntW'(pos_reg) < len_eff || state_reg != F_IDLE)
        else $error("write position past window");
    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> sum_reg == '0 && seen_reg == '0) else $error("config did not clear");
`endif

endmodule

### design/bbf_queue.sv
// Short queue of requests between front and back.
// Depends on bbf_pkg.
module bbf_queue import bbf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     flush,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  bbf_req_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output bbf_req_t rd_data
);

    bbf_req_t  q_reg [QDepth];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      do_wr, do_rd;

    assign wr_ready = cnt_reg != 2'(QDepth);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = q_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) q_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

`ifndef SYNTH
    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(QDepth)) else $error("queue overflow");
    a_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0 || cnt_reg == 2'(QDepth)) |-> wp_reg == rp_reg)
        else $error("queue pointers disagree");
    a_stay: assert property (@(posedge aclk) disable iff (!aresetn || flush)
        rd_valid && !rd_ready |=> rd_valid) else $error("queue lost a request");
`endif

endmodule

### design/bbf_back.sv
// Back end: two serial dividers by window length, variance, serial root, bands.
// Depends on bbf_pkg.
module bbf_back import bbf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     flush,
    input  logic     req_valid,
    output logic     req_ready,
    input  bbf_req_t req,
    output logic     res_valid,
    input  logic     res_ready,
    output bbf_res_t res
);

    typedef enum logic [2:0] {B_IDLE, B_DIV, B_VAR, B_ROOT, B_BAND, B_OUT} bstate_t;

    bstate_t         state_reg;
    logic [5:0]      step_reg;
    logic [CntW-1:0] len_reg;
    logic [SqW-1:0]  dq_reg, qs_reg;   // sum-of-squares dividend/quotient
    logic [SumW-1:0] dm_reg, qm_reg;
    logic [CntW:0]   rs_reg, rm_reg;   // remainders
    logic [2*PriceW-1:0] msq_reg, var_reg, rrem_reg;
    logic [PriceW-1:0]   root_reg;
    logic            full_reg;
    bbf_res_t        res_reg;
    logic [CntW:0]   rs_sh, rm_sh;
    logic [2*PriceW+1:0] trial_rem, trial_sub;

    assign req_ready = (state_reg == B_IDLE);
    assign res_valid = (state_reg == B_OUT);
    assign res       = res_reg;
    assign rs_sh     = {rs_reg[CntW-1:0], dq_reg[SqW-1]};
    assign rm_sh     = {rm_reg[CntW-1:0], dm_reg[SumW-1]};
    assign trial_rem = {rrem_reg, var_reg[2*PriceW-1 -: 2]};
    assign trial_sub = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            state_reg <= B_IDLE;
        end else begin
            case (state_reg)
                B_IDLE: if (req_valid) begin
                    len_reg  <= req.len;
                    full_reg <= req.full;
                    dq_reg   <= req.sq;
                    dm_reg   <= req.sum;
                    qs_reg   <= '0;
                    qm_reg   <= '0;
                    rs_reg   <= '0;
                    rm_reg   <= '0;
                    step_reg <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV: begin
                    dq_reg <= dq_reg << 1;
                    if (rs_sh >= {1'b0, len_reg}) begin
                        rs_reg <= rs_sh - {1'b0, len_reg};
                        qs_reg <= {qs_reg[SqW-2:0], 1'b1};
                    end else begin
                        rs_reg <= rs_sh;
                        qs_reg <= {qs_reg[SqW-2:0], 1'b0};
                    end
                    if (step_reg < 6'(SumW)) begin
                        dm_reg <= dm_reg << 1;
                        if (rm_sh >= {1'b0, len_reg}) begin
                            rm_reg <= rm_sh - {1'b0, len_reg};
                            qm_reg <= {qm_reg[SumW-2:0], 1'b1};
                        end else begin
                            rm_reg <= rm_sh;
                            qm_reg <= {qm_reg[SumW-2:0], 1'b0};
                        end
                    end
                    if (step_reg == 6'(SqW-1)) state_reg <= B_VAR;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'(SumW)) msq_reg <= qm_reg[PriceW-1:0] * qm_reg[PriceW-1:0];
                end
                B_VAR: begin
                    // mean fits 24 bits, so its square fits 48 bits
                    var_reg  <= (qs_reg > SqW'(msq_reg)) ?
                                (2*PriceW)'(qs_reg - SqW'(msq_reg)) : '0;
                    rrem_reg <= '0;
                    root_reg <= '0;
                    step_reg <= '0;
                    state_reg <= B_ROOT;
                end
                B_ROOT: begin
                    var_reg <= var_reg << 2;
                    if (trial_rem >= trial_sub) begin
                        rrem_reg <= (2*PriceW)'(trial_rem - trial_sub);
                        root_reg <= {root_reg[PriceW-2:0], 1'b1};
                    end else begin
                        rrem_reg <= (2*PriceW)'(trial_rem);
                        root_reg <= {root_reg[PriceW-2:0], 1'b0};
                    end
                    if (step_reg == 6'(PriceW-1)) state_reg <= B_BAND;
                    step_reg <= step_reg + 1'b1;
                end
                B_BAND: begin
                    if (full_reg) begin
                        res_reg.valid_res <= 1'b1;
                        res_reg.mean      <= qm_reg[PriceW-1:0];
                        res_reg.deviation <= root_reg;
                        res_reg.band_hi   <= BandW'(qm_reg[PriceW-1:0])
                                             + {1'b0, root_reg, 1'b0};
                        res_reg.band_lo   <= BandW'(qm_reg[PriceW-1:0])
                                             - {1'b0, root_reg, 1'b0};
                    end else begin
                        res_reg <= '0;
                    end
                    state_reg <= B_OUT;
                end
                B_OUT: if (res_ready) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn || flush)
        res_valid && !res_ready |=> $stable(res_reg)) else $error("result changed while held");
    a_warm: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_reg.valid_res |-> res_reg.mean == '0)
        else $error("warm-up result not zero");
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_DIV |-> len_reg != '0) else $error("zero divisor");
`endif

endmodule

### design/bollinger_band_filter.sv
// Bollinger band filter top level: front end, request queue, back end; one result per request.
// The front end steps each sample through F_IDLE, F_READ, F_SQ and F_SEND, the queue holds
// the request, and the back end runs 54 divider steps, 24 root steps, variance and bands.
// The back end takes a new request only in B_IDLE, once the previous result is accepted.
// aresetn is synchronous, active low: window length 20, history empty.
// A write on cfg_wr_en flushes the pipeline and starts warm-up again.
module bollinger_band_filter import bbf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CntW-1:0]   cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // price
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [103:0]      m_tdata,   // mean, deviation, band_hi, band_lo
    output logic              m_tuser    // valid_res
);

    logic     fq_valid, fq_ready, qb_valid, qb_ready;
    bbf_req_t fq_req, qb_req;
    bbf_res_t res;

    bbf_front u_front (
        .aclk, .aresetn,
        .cfg_wr(cfg_wr_en), .cfg_data(cfg_wr_data),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_price(s_tdata),
        .req_valid(fq_valid), .req_ready(fq_ready), .req(fq_req)
    );

    bbf_queue u_queue (
        .aclk, .aresetn, .flush(cfg_wr_en),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_req),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_req)
    );

    bbf_back u_back (
        .aclk, .aresetn, .flush(cfg_wr_en),
        .req_valid(qb_valid), .req_ready(qb_ready), .req(qb_req),
        .res_valid(m_tvalid), .res_ready(m_tready), .res
    );

    assign m_tuser = res.valid_res;
    assign m_tdata = {4'b0000, res.band_lo, res.band_hi, res.deviation, res.mean};

endmodule

### verif/bbf_checker.sv
// Checker for the band filter: watches the config port and both channels, predicts each
// result from its own copy of the window state and compares field by field.
// Depends on bbf_pkg.
module bbf_checker import bbf_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [CntW-1:0] cfg_wr_data,
    input  logic            s_tvalid,
    input  logic            s_tready,
    input  logic [23:0]     s_tdata,
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  logic [103:0]    m_tdata,
    input  logic            m_tuser,
    output int              errors,
    output int              pending,
    output int              results
);

    logic [CntW-1:0]   win_len;
    logic [PriceW-1:0] history [WinMax];
    logic [PosW:0]     wr_pos;
    logic [CntW-1:0]   seen;
    logic [63:0]       run_sum;
    logic [63:0]       run_sq;
    bbf_res_t          band_q[$];

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bit_w;
        root  = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= root + bit_w) begin
                v    = v - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return root;
    endfunction

    task automatic clear_window();
        for (int i = 0; i < WinMax; i++) history[i] = '0;
        wr_pos  = '0;
        seen    = '0;
        run_sum = '0;
        run_sq  = '0;
    endtask

    task automatic take_sample(input logic [PriceW-1:0] price);
        logic [63:0] len, p, old, m, sq_mean, var_w, dev, lo, up;
        bbf_res_t r;
        len = (win_len == 0) ? 1 : (win_len > WinMax) ? WinMax : win_len;
        p   = price;
        if (wr_pos >= len) wr_pos = 0;
        if (seen >= len) begin
            old     = history[wr_pos[PosW-1:0]];
            run_sum = run_sum - old;
            run_sq  = run_sq - old * old;
        end
        history[wr_pos[PosW-1:0]] = price;
        run_sum = run_sum + p;
        run_sq  = run_sq + p * p;
        wr_pos  = wr_pos + 1'b1;
        if (wr_pos >= len) wr_pos = 0;
        if (seen < len) seen = seen + 1'b1;
        r = '0;
        if (seen >= len) begin
            m       = run_sum / len;
            sq_mean = run_sq / len;
            var_w   = (sq_mean > m * m) ? sq_mean - m * m : 0;
            dev     = floor_root(var_w);
            up      = m + 2 * dev;
            lo      = m - 2 * dev;
            r.valid_res = 1'b1;
            r.mean      = m[PriceW-1:0];
            r.deviation = dev[PriceW-1:0];
            r.band_hi   = up[BandW-1:0];
            r.band_lo   = lo[BandW-1:0];
        end
        band_q.insert(band_q.size(), r);
    endtask

    always @(posedge aclk) begin
        bbf_res_t    want;
        logic [99:0] packed_want;
        if (!aresetn) begin
            win_len = LenReset;
            clear_window();
            band_q.delete();
            errors  = 0;
            results = 0;
        end else begin
            if (cfg_wr_en) begin
                win_len = cfg_wr_data;
                clear_window();
            end
            if (s_tvalid && s_tready) take_sample(s_tdata);
            if (m_tvalid && m_tready) begin
                results++;
                if (band_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_tdata,
                             m_tuser);
                end else begin
                    want = band_q.pop_front();
                    // fields packed mean first, as on the port below the padding
                    packed_want = {want.band_lo, want.band_hi, want.deviation,
                                   want.mean};
                    if (m_tuser !== want.valid_res) begin
                        errors++;
                        $display("%0t: valid_res expected %b got %b", $time,
                                 want.valid_res, m_tuser);
                    end
                    if (m_tdata[23:0] !== want.mean) begin
                        errors++;
                        $display("%0t: mean expected %h got %h", $time, want.mean,
                                 m_tdata[23:0]);
                    end
                    if (m_tdata[47:24] !== want.deviation) begin
                        errors++;
                        $display("%0t: deviation expected %h got %h", $time,
                                 want.deviation, m_tdata[47:24]);
                    end
                    if (m_tdata[73:48] !== want.band_hi) begin
                        errors++;
                        $display("%0t: upper band expected %h got %h", $time,
                                 want.band_hi, m_tdata[73:48]);
                    end
                    if (m_tdata[99:74] !== packed_want[99:74]) begin
                        errors++;
                        $display("%0t: lower band expected %h got %h", $time,
                                 packed_want[99:74], m_tdata[99:74]);
                    end
                end
            end
        end
        pending = band_q.size();
    end

endmodule

### verif/testbench.sv
// Testbench top for the band filter: clock, reset, price stimulus over many window
// lengths and idling patterns, watchdog and verdict. Depends on bbf_pkg and bbf_checker.
module testbench;
    import bbf_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CntW-1:0]   cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [103:0]      m_tdata;
    logic              m_tuser;
    int                errors, pending, results;
    int                sent = 0;
    int                n_windows = 0;
    int                send_idle = 0;
    int                recv_stall = 0;
    int                quiet = 0;

    always #4 aclk = ~aclk;

    bollinger_band_filter i_dut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    bbf_checker i_checker (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .errors, .pending, .results
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= 6000) begin
            $display("watchdog: no request moved for %0d cycles", quiet);
            $display("FAIL bollinger_band_filter");
            $finish;
        end
    end

    task automatic send_price(input logic [23:0] price);
        logic hit;
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= price;
        do begin
            @(negedge aclk);
            hit = s_tready;
            @(posedge aclk);
        end while (!hit);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_window(input logic [CntW-1:0] len);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        n_windows++;
    endtask

    function automatic logic [23:0] rand_price(input int style, input logic [23:0] base);
        case (style)
            0: return 24'($urandom);
            1: return 24'($urandom_range(255));
            2: return base ^ 24'($urandom_range(3));
            default: return ($urandom_range(1)) ? 24'hFFFFFF : 24'h000000;
        endcase
    endfunction

    initial begin
        logic [CntW-1:0] len;
        logic [23:0]     base;
        int              style;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset window of 20: zeros, full scale, alternating extremes
        for (int i = 0; i < 22; i++)
            send_price((i < 3) ? 24'h0 : (i < 12) ? 24'hFFFFFF : (i[0] ? 24'hFFFFFF : 24'h0));
        set_window(7'd1);
        send_price(24'hFFFFFF);
        send_price(24'h000001);
        set_window(7'd0);
        send_price(24'hAAAAAA);
        send_price(24'h555555);

        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 47; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 47; end
                default: begin send_idle = 20; recv_stall = 20; end
            endcase
            case (ph)
                0: len = 7'd64;
                1: len = 7'd127;
                2: len = 7'd2;
                3: len = 7'd65;
                4: len = 7'd1;
                default: len = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                       : 7'($urandom_range(1, 12));
            endcase
            set_window(len);
            style = int'($urandom_range(3));
            base  = 24'($urandom);
            for (int i = 0; i < 100; i++) begin
                if (i == 50 && ph == 5) drain();
                if ($urandom_range(9) == 0) style = int'($urandom_range(3));
                send_price(rand_price(style, base));
            end
        end
        drain();

        $display("covered %0d price samples and %0d results over %0d window settings",
                 sent, results, n_windows + 1);
        $display("with free-running, sender-idle, receiver-stall and mixed idling phases");
        if (errors == 0) begin
            $display("PASS bollinger_band_filter");
        end else begin
            $display("FAIL bollinger_band_filter");
        end
        $finish;
    end

endmodule
